@@ rtl/vrs_pkg.sv @@
// Shared types and codes of the variable record stack.
`timescale 1ns / 1ps

package vrs_pkg;

   localparam int LEN_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int FREE_W   = 11;

   // Request kinds.
   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_PEEK  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_PUSHED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_ROOM = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_POPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_PEEKED  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd5;

   typedef struct packed {
      logic [1:0]        kind;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                last;
      logic                is_empty;
      logic [FREE_W-1:0]   free_bytes;
   } rsp_type;

   // One result as the controller produces it, before the occupancy fields.
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                last;
   } emit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEADER,
      ST_STREAM
   } state_type;

endpackage

@@ rtl/vrs_mem.sv @@
// Byte store of the stack: one write port, one read port with registered data.
`timescale 1ns / 1ps

module vrs_mem import vrs_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_array [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/vrs_ctrl.sv @@
// Stack controller: push runs, pop and peek sequencing, and the top pointer.
`timescale 1ns / 1ps

module vrs_ctrl import vrs_pkg::*; #(
   parameter int CAPACITY     = 1024,
   parameter int HEADER_BYTES = 4,
   parameter int MAX_RECORD   = 64,
   parameter int TW           = 11,
   parameter int AW           = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req,
   output logic              busy,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   output emit_type          emit,
   output logic [TW-1:0]     top_next
);

   localparam int CW = ((TW > LEN_W) ? TW : LEN_W) + 1;

   state_type        state_ff, state_in;
   logic [TW-1:0]    top_ff, top_in;
   logic [LEN_W-1:0] push_left_ff, push_left_in;
   logic             push_drop_ff, push_drop_in;
   logic [LEN_W-1:0] push_len_ff, push_len_in;
   logic             is_pop_ff, is_pop_in;
   logic [LEN_W-1:0] want_ff, want_in;
   logic [TW-1:0]    base_ff, base_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] idx_ff, idx_in;

   logic             accept;
   logic             empty;
   logic             is_pop_req;
   logic [CW-1:0]    top_ext;
   logic [CW-1:0]    len_ext;
   logic [CW-1:0]    hdr_pos;
   logic [CW-1:0]    data_pos;
   logic [CW-1:0]    fin_pos;
   logic [CW-1:0]    pop_top;
   logic [CW-1:0]    stream_pos;
   logic [CW-1:0]    first_pos;
   logic             no_room;
   logic [LEN_W-1:0] count;
   logic [STATUS_W-1:0] read_status;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign empty      = (top_ff >= TW'(CAPACITY));
   assign is_pop_req = (req.kind == KIND_POP) || (req.kind == KIND_PEEK);

   assign top_ext    = CW'(top_ff);
   assign len_ext    = CW'(req.length);
   assign hdr_pos    = top_ext - len_ext - CW'(HEADER_BYTES);
   assign data_pos   = top_ext - CW'(push_left_ff);
   assign fin_pos    = top_ext - CW'(push_len_ff) - CW'(HEADER_BYTES);
   assign pop_top    = CW'(base_ff) + CW'(rd_data);
   assign first_pos  = CW'(base_ff);
   assign stream_pos = CW'(base_ff) + CW'(idx_ff);
   assign no_room    = (len_ext > CW'(MAX_RECORD)) ||
                       ((len_ext + CW'(HEADER_BYTES)) > top_ext);

   // Bytes to return: the smaller of the requested and the stored length.
   // Only the low header byte is ever written or read since records are short.
   assign count       = ({1'b0, want_ff} < rd_data) ? want_ff : rd_data[LEN_W-1:0];
   assign read_status = is_pop_ff ? STAT_POPPED : STAT_PEEKED;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (push_left_ff == '0) && is_pop_req && !empty) begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            state_in = (count == '0) ? ST_IDLE : ST_STREAM;
         end
         ST_STREAM: begin
            if (left_ff == LEN_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      top_in       = top_ff;
      push_left_in = push_left_ff;
      push_drop_in = push_drop_ff;
      push_len_in  = push_len_ff;
      is_pop_in    = is_pop_ff;
      want_in      = want_ff;
      base_in      = base_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      emit         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (push_left_ff != '0) begin
                  push_left_in = push_left_ff - LEN_W'(1);
                  if (push_drop_ff) begin
                     if (push_left_ff == LEN_W'(1)) begin
                        push_drop_in = 1'b0;
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = data_pos[AW-1:0];
                     wr_data = req.data_byte;
                     if (push_left_ff == LEN_W'(1)) begin
                        top_in      = fin_pos[TW-1:0];
                        emit.valid  = 1'b1;
                        emit.status = STAT_PUSHED;
                        emit.last   = 1'b1;
                     end
                  end
               end else begin
                  case (req.kind)
                     KIND_PUSH: begin
                        push_len_in = req.length;
                        if (no_room) begin
                           push_left_in = req.length;
                           push_drop_in = (req.length != '0);
                           emit.valid   = 1'b1;
                           emit.status  = STAT_NO_ROOM;
                           emit.last    = 1'b1;
                        end else begin
                           // The header goes in at once; nothing reads the
                           // store until the run has finished.
                           wr_en        = 1'b1;
                           wr_addr      = hdr_pos[AW-1:0];
                           wr_data      = {1'b0, req.length};
                           push_drop_in = 1'b0;
                           if (req.length == '0) begin
                              top_in      = hdr_pos[TW-1:0];
                              emit.valid  = 1'b1;
                              emit.status = STAT_PUSHED;
                              emit.last   = 1'b1;
                           end else begin
                              push_left_in = req.length;
                           end
                        end
                     end
                     KIND_CLEAR: begin
                        top_in      = TW'(CAPACITY);
                        emit.valid  = 1'b1;
                        emit.status = STAT_CLEARED;
                        emit.last   = 1'b1;
                     end
                     default: begin
                        if (empty) begin
                           emit.valid  = 1'b1;
                           emit.status = STAT_EMPTY;
                           emit.last   = 1'b1;
                        end else begin
                           rd_en     = 1'b1;
                           rd_addr   = top_ff[AW-1:0];
                           is_pop_in = (req.kind == KIND_POP);
                           want_in   = req.length;
                           base_in   = top_ff + TW'(HEADER_BYTES);
                        end
                     end
                  endcase
               end
            end
         end
         ST_HEADER: begin
            if (is_pop_ff) begin
               top_in = pop_top[TW-1:0];
            end
            if (count == '0) begin
               emit.valid  = 1'b1;
               emit.status = read_status;
               emit.last   = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = first_pos[AW-1:0];
               idx_in  = LEN_W'(1);
               left_in = count;
            end
         end
         ST_STREAM: begin
            emit.valid      = 1'b1;
            emit.status     = read_status;
            emit.out_byte   = rd_data;
            emit.byte_valid = 1'b1;
            emit.last       = (left_ff == LEN_W'(1));
            left_in         = left_ff - LEN_W'(1);
            if (left_ff != LEN_W'(1)) begin
               rd_en   = 1'b1;
               rd_addr = stream_pos[AW-1:0];
               idx_in  = idx_ff + LEN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign top_next = top_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= TW'(CAPACITY);
         push_left_ff <= '0;
         push_drop_ff <= 1'b0;
         push_len_ff  <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         push_left_ff <= push_left_in;
         push_drop_ff <= push_drop_in;
         push_len_ff  <= push_len_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      is_pop_ff <= is_pop_in;
      want_ff   <= want_in;
      base_ff   <= base_in;
      idx_ff    <= idx_in;
   end

   // A push run never overlaps a read sequence.
   a_run_idle: assert property (@(posedge clock) disable iff (reset)
      (push_left_ff != '0) |-> (state_ff == ST_IDLE))
      else $error("push run in progress outside idle");

   // The streaming state always has bytes left to send.
   a_stream_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (left_ff != '0))
      else $error("streaming with no bytes left");

   // The top pointer never passes the end of the store.
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TW'(CAPACITY))
      else $error("top pointer beyond capacity");

   // In idle, a result only comes from an accepted item.
   a_idle_emit: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && (state_ff == ST_IDLE)) |-> accept)
      else $error("result without accepted item");

   // After a header read the sequence either ends or streams.
   a_header_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEADER) |=> (state_ff == ST_IDLE) || (state_ff == ST_STREAM))
      else $error("bad state after header read");

endmodule

@@ rtl/variable_record_stack.sv @@
// Top level of the variable record stack: controller, byte store and result register.
`timescale 1ns / 1ps

// A stack of variable-length records held in a byte store of CAPACITY bytes
// that grows downward. Each record sits above a HEADER_BYTES length header.
// An item is taken when start is high and busy is low. A push is a run of
// items: the first gives the length, each following item carries one data
// byte, and the final byte produces a single "pushed" result. A push that
// does not fit, or is longer than MAX_RECORD, reports "no room" at once and
// its data bytes are swallowed silently. Push items, clear and the empty
// case of pop or peek never raise busy. A pop or peek of a non-empty stack
// first reads the header from the store, then the single read port
// supplies one byte per cycle, and busy stays high meanwhile. Results appear
// on rsp_data for exactly one cycle, marked by rsp_strobe, in the cycle after
// the cycle that produced them; the receiver cannot stall them. Every result
// carries is_empty and free_bytes as they stand after the item. The store
// needs no initialization after reset, so the block takes items from the
// first cycle out of reset.
module variable_record_stack import vrs_pkg::*; #(
   parameter int CAPACITY     = 1024,
   parameter int HEADER_BYTES = 4,
   parameter int MAX_RECORD   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int TW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   emit_type          emit;
   logic [TW-1:0]     top_next;

   logic [TW+FREE_W-1:0] top_wide;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   vrs_ctrl #(
      .CAPACITY     (CAPACITY),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_RECORD   (MAX_RECORD),
      .TW           (TW),
      .AW           (AW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .emit     (emit),
      .top_next (top_next)
   );

   vrs_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The free count is the top pointer itself, reported in eleven bits.
   assign top_wide = {{FREE_W{1'b0}}, top_next};

   always_comb begin
      rsp_strobe_in          = emit.valid;
      rsp_data_in.status     = emit.status;
      rsp_data_in.out_byte   = emit.out_byte;
      rsp_data_in.byte_valid = emit.byte_valid;
      rsp_data_in.last       = emit.last;
      rsp_data_in.is_empty   = (top_next >= TW'(CAPACITY));
      rsp_data_in.free_bytes = top_wide[FREE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
